// ===== src/bmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bmp_pkg;

  localparam int unsigned ValW = 30;
  localparam int unsigned ArgW = 10;
  localparam int unsigned DefaultMaxN = 1024;

  localparam logic [ValW-1:0] PRIME = 30'd998244353;
  localparam logic [ValW-1:0] FERMAT_EXP = PRIME - 30'd2;
  localparam int unsigned ExpBitW = 5;
  localparam logic [ExpBitW-1:0] EXP_TOP_BIT = 5'(ValW - 1);

  // barrett constant floor(2^60 / p), fits in 31 bits
  localparam logic [63:0] BARRETT_MU_64 = (64'd1 << 60) / {34'd0, PRIME};
  localparam logic [30:0] BARRETT_MU = BARRETT_MU_64[30:0];

  typedef enum logic [3:0] {
    ST_INIT,
    ST_FACT_MUL,
    ST_FACT_WAIT,
    ST_POW_ACC,
    ST_POW_ACC_WAIT,
    ST_POW_SQ,
    ST_POW_SQ_WAIT,
    ST_INV_MUL,
    ST_INV_WAIT,
    ST_READY
  } build_st_e;

  typedef struct packed {
    logic            valid;
    logic [ValW-1:0] a;
    logic [ValW-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic            fact_we;
    logic            inv_we;
    logic [ValW-1:0] data;
  } tbl_wr_t;

endpackage
`default_nettype wire

// ===== src/binomial_mod_prime.sv =====
`timescale 1ns / 1ps
`default_nettype none
// n choose m modulo 998244353, from factorial and inverse factorial tables.
//
// queries: a transaction is taken at a clock edge where start_i is high and
// busy_o is low; n_value_i and m_value_i are sampled there. one query can be
// taken every cycle.
// results: done_o is high for one cycle with binomial_value_o, in query
// order. the receiver cannot stall, so nothing backs up. m above n, or n at
// or beyond MAX_N, gives zero.
// each query reads three table entries, then runs two four-stage modular
// multipliers back to back.
// reset: after rst_ni is released the tables are rebuilt through one shared
// modular multiplier, one entry at a time, factorials upward, then a fermat
// inverse by square-and-multiply (at most 60 products), then inverse
// factorials downward. busy_o is high for that whole build and low for good
// afterward.
module binomial_mod_prime import bmp_pkg::*; #(
  parameter int unsigned MAX_N = DefaultMaxN
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire logic [ArgW-1:0] n_value_i,
  input  wire logic [ArgW-1:0] m_value_i,
  output logic                 done_o,
  output logic      [ValW-1:0] binomial_value_o
);

  localparam int unsigned AddrW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int unsigned IdxW = (AddrW > ArgW) ? AddrW : ArgW;
  localparam int unsigned Tag1W = ValW + 1;

  logic             accept;
  logic [IdxW-1:0]  n_ext, nm_ext, m_ext;
  logic [ArgW-1:0]  n_minus_m;
  logic             zero_d;
  logic             q1_valid_q, q1_zero_q;
  logic [ValW-1:0]  fact_rd, inv_a_rd, inv_b_rd;

  mm_req_t          bld_req;
  tbl_wr_t          bld_wr;
  logic [AddrW-1:0] bld_waddr;
  logic             bld_ready;

  logic             mm1_valid_in, mm1_valid_out;
  logic [ValW-1:0]  mm1_a, mm1_b, mm1_res;
  logic [Tag1W-1:0] mm1_tag_out;
  logic             mm2_valid_out;
  logic [ValW-1:0]  mm2_res;
  logic             mm2_zero;

  assign busy_o    = !bld_ready;
  assign accept    = start_i && !busy_o;
  assign n_minus_m = n_value_i - m_value_i;
  assign n_ext     = IdxW'(n_value_i);
  assign nm_ext    = IdxW'(n_minus_m);
  assign m_ext     = IdxW'(m_value_i);
  assign zero_d    = (m_value_i > n_value_i) || (32'(n_value_i) >= MAX_N);

  bmp_builder #(.MAX_N(MAX_N)) u_builder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (mm1_valid_out && !bld_ready),
    .res_i       (mm1_res),
    .req_o       (bld_req),
    .wr_o        (bld_wr),
    .waddr_o     (bld_waddr),
    .ready_o     (bld_ready)
  );

  bmp_ram #(.WIDTH(ValW), .DEPTH(MAX_N)) u_fact_ram (
    .clk_i   (clk_i),
    .we_i    (bld_wr.fact_we),
    .waddr_i (bld_waddr),
    .wdata_i (bld_wr.data),
    .raddr_i (n_ext[AddrW-1:0]),
    .rdata_o (fact_rd)
  );

  // two copies of the inverse table give the two reads per query
  bmp_ram #(.WIDTH(ValW), .DEPTH(MAX_N)) u_inv_a_ram (
    .clk_i   (clk_i),
    .we_i    (bld_wr.inv_we),
    .waddr_i (bld_waddr),
    .wdata_i (bld_wr.data),
    .raddr_i (nm_ext[AddrW-1:0]),
    .rdata_o (inv_a_rd)
  );

  bmp_ram #(.WIDTH(ValW), .DEPTH(MAX_N)) u_inv_b_ram (
    .clk_i   (clk_i),
    .we_i    (bld_wr.inv_we),
    .waddr_i (bld_waddr),
    .wdata_i (bld_wr.data),
    .raddr_i (m_ext[AddrW-1:0]),
    .rdata_o (inv_b_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_valid_q <= 1'b0;
    end else begin
      q1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_zero_q <= zero_d;
  end

  // multiplier one is shared with the table build
  always_comb begin
    if (bld_ready) begin
      mm1_valid_in = q1_valid_q;
      mm1_a        = fact_rd;
      mm1_b        = inv_a_rd;
    end else begin
      mm1_valid_in = bld_req.valid;
      mm1_a        = bld_req.a;
      mm1_b        = bld_req.b;
    end
  end

  bmp_modmul #(.TAG_W(Tag1W)) u_mm1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mm1_valid_in),
    .a_i     (mm1_a),
    .b_i     (mm1_b),
    .tag_i   ({q1_zero_q, inv_b_rd}),
    .valid_o (mm1_valid_out),
    .prod_o  (mm1_res),
    .tag_o   (mm1_tag_out)
  );

  bmp_modmul #(.TAG_W(1)) u_mm2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mm1_valid_out && bld_ready),
    .a_i     (mm1_res),
    .b_i     (mm1_tag_out[ValW-1:0]),
    .tag_i   (mm1_tag_out[ValW]),
    .valid_o (mm2_valid_out),
    .prod_o  (mm2_res),
    .tag_o   (mm2_zero)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= mm2_valid_out;
    end
  end

  always_ff @(posedge clk_i) begin
    binomial_value_o <= mm2_zero ? '0 : mm2_res;
  end

  a_done_after_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while tables are building");

  a_build_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o) else $error("busy reasserted after build");

  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (binomial_value_o < PRIME)) else $error("result not reduced");

  a_accept_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##10 done_o) else $error("result latency mismatch");

endmodule
`default_nettype wire

// ===== src/bmp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmp_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== src/bmp_modmul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmp_modmul import bmp_pkg::*; #(
  parameter int unsigned TAG_W = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [ValW-1:0]  a_i,
  input  wire logic [ValW-1:0]  b_i,
  input  wire logic [TAG_W-1:0] tag_i,
  output logic                  valid_o,
  output logic      [ValW-1:0]  prod_o,
  output logic      [TAG_W-1:0] tag_o
);

  logic [2:0]       v_q;
  logic [TAG_W-1:0] tag1_q, tag2_q, tag3_q;
  logic [59:0]      x_q;
  logic [30:0]      quo_q;
  logic [31:0]      xlo_q;
  logic [31:0]      rem_q;
  logic [61:0]      quo_full;
  logic [60:0]      qp_full;
  logic [31:0]      rem_d;
  logic [ValW-1:0]  res_d;

  // barrett estimate, at most two short of the true quotient
  assign quo_full = 62'(x_q[59:29]) * 62'(BARRETT_MU);
  assign qp_full  = 61'(quo_q) * 61'(PRIME);
  assign rem_d    = xlo_q - qp_full[31:0];

  always_comb begin
    if (rem_q >= {1'b0, PRIME, 1'b0}) begin
      res_d = ValW'(rem_q - {1'b0, PRIME, 1'b0});
    end else if (rem_q >= {2'b0, PRIME}) begin
      res_d = ValW'(rem_q - {2'b0, PRIME});
    end else begin
      res_d = rem_q[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else begin
      v_q     <= {v_q[1:0], valid_i};
      valid_o <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= 60'(a_i) * 60'(b_i);
    tag1_q <= tag_i;
    quo_q  <= quo_full[61:31];
    xlo_q  <= x_q[31:0];
    tag2_q <= tag1_q;
    rem_q  <= rem_d;
    tag3_q <= tag2_q;
    prod_o <= res_d;
    tag_o  <= tag3_q;
  end

endmodule
`default_nettype wire

// ===== src/bmp_builder.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmp_builder import bmp_pkg::*; #(
  parameter int unsigned MAX_N = DefaultMaxN,
  localparam int unsigned AddrW = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             res_valid_i,
  input  wire logic [ValW-1:0]  res_i,
  output mm_req_t               req_o,
  output tbl_wr_t               wr_o,
  output logic      [AddrW-1:0] waddr_o,
  output logic                  ready_o
);

  localparam logic [AddrW-1:0] LastIdx = AddrW'(MAX_N - 1);

  build_st_e          state_q, state_d;
  logic [ValW-1:0]    acc_q, acc_d;
  logic [ValW-1:0]    sq_q, sq_d;
  logic [AddrW-1:0]   cnt_q, cnt_d;
  logic [ExpBitW-1:0] ebit_q, ebit_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:     state_d = ST_FACT_MUL;
      ST_FACT_MUL: state_d = ST_FACT_WAIT;
      ST_FACT_WAIT: begin
        if (res_valid_i) begin
          state_d = (cnt_q == LastIdx) ? ST_POW_ACC : ST_FACT_MUL;
        end
      end
      ST_POW_ACC: state_d = FERMAT_EXP[ebit_q] ? ST_POW_ACC_WAIT : ST_POW_SQ;
      ST_POW_ACC_WAIT: begin
        if (res_valid_i) begin
          state_d = ST_POW_SQ;
        end
      end
      ST_POW_SQ: state_d = (ebit_q == EXP_TOP_BIT) ? ST_INV_MUL : ST_POW_SQ_WAIT;
      ST_POW_SQ_WAIT: begin
        if (res_valid_i) begin
          state_d = ST_POW_ACC;
        end
      end
      ST_INV_MUL: state_d = ST_INV_WAIT;
      ST_INV_WAIT: begin
        if (res_valid_i) begin
          state_d = (cnt_q == AddrW'(1)) ? ST_READY : ST_INV_MUL;
        end
      end
      ST_READY: state_d = ST_READY;
      default:  state_d = ST_INIT;
    endcase
  end

  always_comb begin
    req_o   = '{valid: 1'b0, a: acc_q, b: ValW'(cnt_q)};
    wr_o    = '{fact_we: 1'b0, inv_we: 1'b0, data: res_i};
    waddr_o = cnt_q;
    acc_d   = acc_q;
    sq_d    = sq_q;
    cnt_d   = cnt_q;
    ebit_d  = ebit_q;
    case (state_q)
      ST_INIT: begin
        wr_o.fact_we = 1'b1;
        wr_o.data    = ValW'(1);
        waddr_o      = '0;
        acc_d        = ValW'(1);
        cnt_d        = AddrW'(1);
      end
      ST_FACT_MUL: req_o.valid = 1'b1;
      ST_FACT_WAIT: begin
        if (res_valid_i) begin
          wr_o.fact_we = 1'b1;
          if (cnt_q == LastIdx) begin
            sq_d   = res_i;
            acc_d  = ValW'(1);
            ebit_d = '0;
          end else begin
            acc_d = res_i;
            cnt_d = cnt_q + AddrW'(1);
          end
        end
      end
      ST_POW_ACC: begin
        req_o.valid = FERMAT_EXP[ebit_q];
        req_o.b     = sq_q;
      end
      ST_POW_ACC_WAIT: begin
        if (res_valid_i) begin
          acc_d = res_i;
        end
      end
      ST_POW_SQ: begin
        if (ebit_q == EXP_TOP_BIT) begin
          // acc now holds the inverse of the top factorial
          wr_o.inv_we = 1'b1;
          wr_o.data   = acc_q;
          waddr_o     = LastIdx;
          cnt_d       = LastIdx;
        end else begin
          req_o = '{valid: 1'b1, a: sq_q, b: sq_q};
        end
      end
      ST_POW_SQ_WAIT: begin
        if (res_valid_i) begin
          sq_d   = res_i;
          ebit_d = ebit_q + ExpBitW'(1);
        end
      end
      ST_INV_MUL: req_o.valid = 1'b1;
      ST_INV_WAIT: begin
        waddr_o = cnt_q - AddrW'(1);
        if (res_valid_i) begin
          wr_o.inv_we = 1'b1;
          acc_d       = res_i;
          cnt_d       = cnt_q - AddrW'(1);
        end
      end
      ST_READY: ;
      default: ;
    endcase
  end

  assign ready_o = (state_q == ST_READY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      acc_q   <= '0;
      sq_q    <= '0;
      cnt_q   <= '0;
      ebit_q  <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      sq_q    <= sq_d;
      cnt_q   <= cnt_d;
      ebit_q  <= ebit_d;
    end
  end

endmodule
`default_nettype wire

// ===== test/binomial_mod_prime_checker.sv =====
`timescale 1ns / 1ps
module binomial_mod_prime_checker import bmp_pkg::*; #(
  parameter int unsigned MAX_N = DefaultMaxN
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  logic [ArgW-1:0] n_value_i,
  input  logic [ArgW-1:0] m_value_i,
  input  logic            done_i,
  input  logic [ValW-1:0] binomial_value_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              query_count_o,
  output int              zero_count_o
);

  localparam logic [63:0] P64 = {34'd0, PRIME};

  logic [ValW-1:0] fact_q [MAX_N];
  logic [ValW-1:0] inv_fact_q [MAX_N];
  logic [ValW-1:0] expected_binomials [$];

  function automatic logic [ValW-1:0] mod_mul(logic [ValW-1:0] a, logic [ValW-1:0] b);
    logic [63:0] prod;
    prod = {34'd0, a} * {34'd0, b};
    return ValW'(prod % P64);
  endfunction

  function automatic logic [ValW-1:0] mod_pow(logic [ValW-1:0] b, logic [ValW-1:0] e);
    logic [ValW-1:0] acc;
    logic [ValW-1:0] sq;
    acc = 1;
    sq = b;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, sq);
      sq = mod_mul(sq, sq);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [ValW-1:0] choose_mod(logic [ArgW-1:0] n, logic [ArgW-1:0] m);
    if (m > n || n >= MAX_N) return '0;
    return mod_mul(mod_mul(fact_q[n], inv_fact_q[n-m]), inv_fact_q[m]);
  endfunction

  initial begin
    fact_q[0] = 1;
    for (int i = 1; i < MAX_N; i++) fact_q[i] = mod_mul(fact_q[i-1], ValW'(i));
    inv_fact_q[MAX_N-1] = mod_pow(fact_q[MAX_N-1], FERMAT_EXP);
    for (int i = MAX_N - 1; i > 0; i--) inv_fact_q[i-1] = mod_mul(inv_fact_q[i], ValW'(i));
  end

  assign pending_o = expected_binomials.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [ValW-1:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      query_count_o <= 0;
      zero_count_o <= 0;
      expected_binomials.delete();
    end else begin
      // result first, so a same-edge query never matches itself
      if (done_i) begin
        if (expected_binomials.size() == 0) begin
          $error("unexpected result binomial_value=%0d", binomial_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_binomials.pop_front();
          if (want !== binomial_value_i) begin
            $error("binomial_value expected %0d actual %0d", want, binomial_value_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        want = choose_mod(n_value_i, m_value_i);
        expected_binomials.push_back(want);
        query_count_o <= query_count_o + 1;
        if (want == 0) zero_count_o <= zero_count_o + 1;
      end
    end
  end

endmodule

// ===== test/tb_binomial_mod_prime.sv =====
`timescale 1ns / 1ps
module tb_binomial_mod_prime;
  import bmp_pkg::*;

  localparam int unsigned MAX_N = DefaultMaxN;
  localparam int DirectedCount = 18;
  localparam int RandomCount = 550;
  // the whole table build passes with no transaction before the first acceptance
  localparam int WatchdogLimit = 40 * MAX_N + 4000;

  logic            clk_i = 0;
  logic            rst_ni = 0;
  logic            start_i = 0;
  logic [ArgW-1:0] n_value_i = '0;
  logic [ArgW-1:0] m_value_i = '0;
  logic            busy_o;
  logic            done_o;
  logic [ValW-1:0] binomial_value_o;
  int              fail_count;
  int              pending;
  int              query_count;
  int              zero_count;
  int              idle_cycles = 0;

  logic [ArgW-1:0] dn [DirectedCount] = '{0, 0, 1, 1, 1, 1023, 1023, 1023, 1023,
    1023, 5, 5, 512, 1022, 1000, 0, 1023, 682};
  logic [ArgW-1:0] dm [DirectedCount] = '{0, 1, 0, 1, 2, 0, 1023, 511, 512,
    1, 6, 1023, 256, 1023, 999, 1023, 1022, 341};

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  binomial_mod_prime #(.MAX_N(MAX_N)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .n_value_i, .m_value_i, .done_o,
    .binomial_value_o
  );

  binomial_mod_prime_checker #(.MAX_N(MAX_N)) checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .n_value_i, .m_value_i,
    .done_i(done_o), .binomial_value_i(binomial_value_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .query_count_o(query_count), .zero_count_o(zero_count)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // holds start until the transaction is taken; start stays high between items
  task automatic send_query(input logic [ArgW-1:0] n, input logic [ArgW-1:0] m);
    n_value_i <= n;
    m_value_i <= m;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic pause(input int cycles);
    start_i <= 1'b0;
    n_value_i <= ArgW'($urandom);
    m_value_i <= ArgW'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    int burst;
    int n;
    bit drained;
    drained = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirectedCount; i++) send_query(dn[i], dm[i]);
    pause(3);

    sent = 0;
    while (sent < RandomCount) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < RandomCount; i++, sent++) begin
        case ($urandom_range(0, 9))
          0: send_query(ArgW'($urandom), ArgW'($urandom));
          1: begin
            n = $urandom_range(0, 1022);
            send_query(ArgW'(n), ArgW'($urandom_range(n + 1, 1023)));
          end
          2: send_query(ArgW'($urandom_range(1000, 1023)), ArgW'($urandom_range(0, 30)));
          default: begin
            n = $urandom_range(0, 1023);
            send_query(ArgW'(n), ArgW'($urandom_range(0, n)));
          end
        endcase
      end
      if (!drained && sent >= RandomCount / 2) begin
        // drain the pipeline completely once
        drained = 1'b1;
        start_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end else if ($urandom_range(0, 3) != 0) begin
        pause($urandom_range(1, 12));
      end
    end
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("queries checked: %0d (%0d with a zero answer), failures: %0d",
             query_count, zero_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
